FILE: design/affine_point_rect_transform_core_assert.svh
// Assertion macros used by the checker file of the affine transform core
`ifndef AFFINE_POINT_RECT_TRANSFORM_CORE_ASSERT_SVH
`define AFFINE_POINT_RECT_TRANSFORM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define APRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define APRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/aprt_pkg.sv
// Package: widths, register indexes, opcodes and reset values of the affine transform core
`default_nettype none
package aprt_pkg;

	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int NUM_PROD      = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A  = 3'd0,
		REG_COEF_B  = 3'd1,
		REG_COEF_C  = 3'd2,
		REG_COEF_D  = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5
	} cfg_reg_t;

	// opcodes of an input request
	localparam logic OP_POINT = 1'b0;
	localparam logic OP_RECT  = 1'b1;

	// reset values: identity matrix, no translation
	localparam logic signed [WORD_W-1:0] COEF_ONE_RST  = 32'sd65536;
	localparam logic signed [WORD_W-1:0] COEF_ZERO_RST = 32'sd0;

endpackage
`default_nettype wire

FILE: design/aprt_item_if.sv
// Input channel: one point or rectangle request with valid/ready handshake
`default_nettype none
interface aprt_item_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 opcode;
	logic signed [aprt_pkg::WORD_W-1:0]   x_first;
	logic signed [aprt_pkg::WORD_W-1:0]   y_first;
	logic signed [aprt_pkg::WORD_W-1:0]   x_second;
	logic signed [aprt_pkg::WORD_W-1:0]   y_second;

	modport source (output valid, opcode, x_first, y_first, x_second, y_second, input ready);
	modport sink   (input valid, opcode, x_first, y_first, x_second, y_second, output ready);
endinterface
`default_nettype wire

FILE: design/aprt_result_if.sv
// Output channel: transformed bounding box with valid/ready handshake
`default_nettype none
interface aprt_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [aprt_pkg::WORD_W-1:0]   min_x;
	logic signed [aprt_pkg::WORD_W-1:0]   min_y;
	logic signed [aprt_pkg::WORD_W-1:0]   max_x;
	logic signed [aprt_pkg::WORD_W-1:0]   max_y;

	modport source (output valid, min_x, min_y, max_x, max_y, input ready);
	modport sink   (input valid, min_x, min_y, max_x, max_y, output ready);
endinterface
`default_nettype wire

FILE: design/affine_point_rect_transform_core.sv
// Top level: pipelined 2D affine transform of points and rectangle bounding boxes
//
// Takes one request per clock unless stalled; one result per request, in order.
// A request is transformed by the matrix [a b; c d] plus (shift_x, shift_y) in
// signed fixed point with FRAC_BITS fraction bits; products are truncated toward
// minus infinity and all sums wrap to 32 bits. A point request returns the point
// as both min and max; a rectangle request returns the box around its four
// transformed corners. Stage 1 holds the eight 32x32 products, stage 2 the
// corner sums, stage 3 the pairwise min/max, stage 4 the output register.
// Sustained rate is one request per cycle while the result side accepts; a
// result stall holds valid stages, lets bubbles close up and drops input ready
// only once the pipeline is full. The user must write the coefficients through
// the plain write port while no request is in flight; it is not enforced.
`default_nettype none
module affine_point_rect_transform_core #(
	parameter int FRAC_BITS = aprt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [aprt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [aprt_pkg::WORD_W-1:0]         cfg_data,
	aprt_item_if.sink                                item,
	aprt_result_if.source                            result
);

	localparam int W  = aprt_pkg::WORD_W;
	localparam int NP = aprt_pkg::NUM_PROD;

	// configuration registers
	logic signed [W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, shift_x_q, shift_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= aprt_pkg::COEF_ONE_RST;
			coef_b_q  <= aprt_pkg::COEF_ZERO_RST;
			coef_c_q  <= aprt_pkg::COEF_ZERO_RST;
			coef_d_q  <= aprt_pkg::COEF_ONE_RST;
			shift_x_q <= aprt_pkg::COEF_ZERO_RST;
			shift_y_q <= aprt_pkg::COEF_ZERO_RST;
		end else if (cfg_we) begin
			case (aprt_pkg::cfg_reg_t'(cfg_index))
				aprt_pkg::REG_COEF_A:  coef_a_q  <= $signed(cfg_data);
				aprt_pkg::REG_COEF_B:  coef_b_q  <= $signed(cfg_data);
				aprt_pkg::REG_COEF_C:  coef_c_q  <= $signed(cfg_data);
				aprt_pkg::REG_COEF_D:  coef_d_q  <= $signed(cfg_data);
				aprt_pkg::REG_SHIFT_X: shift_x_q <= $signed(cfg_data);
				aprt_pkg::REG_SHIFT_Y: shift_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage valids and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || result.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign item.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: eight products, order ax0 by0 cx0 dy0 ax1 by1 cx1 dy1
	logic signed [W-1:0]   mul_coef [NP];
	logic signed [W-1:0]   mul_pt   [NP];
	logic signed [2*W-1:0] mul_full [NP];
	logic signed [W-1:0]   prod_s1  [NP];
	logic                  op_s1;

	always_comb begin
		mul_coef[0] = coef_a_q;  mul_pt[0] = item.x_first;
		mul_coef[1] = coef_b_q;  mul_pt[1] = item.y_first;
		mul_coef[2] = coef_c_q;  mul_pt[2] = item.x_first;
		mul_coef[3] = coef_d_q;  mul_pt[3] = item.y_first;
		mul_coef[4] = coef_a_q;  mul_pt[4] = item.x_second;
		mul_coef[5] = coef_b_q;  mul_pt[5] = item.y_second;
		mul_coef[6] = coef_c_q;  mul_pt[6] = item.x_second;
		mul_coef[7] = coef_d_q;  mul_pt[7] = item.y_second;
	end

	for (genvar k = 0; k < NP; k++) begin : g_mul
		assign mul_full[k] = mul_coef[k] * mul_pt[k];
	end

	// arithmetic shift then low word is the same as this slice
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= item.opcode;
			for (int k = 0; k < NP; k++) begin
				prod_s1[k] <= mul_full[k][FRAC_BITS +: W];
			end
		end
	end

	// stage 2: corner sums; a point repeats corner 0
	logic signed [W-1:0] cx_s2 [4];
	logic signed [W-1:0] cy_s2 [4];
	logic signed [W-1:0] cx0, cx1, cx2, cx3, cy0, cy1, cy2, cy3;
	logic                is_rect;

	assign is_rect = (op_s1 == aprt_pkg::OP_RECT);
	assign cx0 = prod_s1[0] + prod_s1[1] + shift_x_q;
	assign cy0 = prod_s1[2] + prod_s1[3] + shift_y_q;
	assign cx1 = prod_s1[4] + prod_s1[1] + shift_x_q;
	assign cy1 = prod_s1[6] + prod_s1[3] + shift_y_q;
	assign cx2 = prod_s1[0] + prod_s1[5] + shift_x_q;
	assign cy2 = prod_s1[2] + prod_s1[7] + shift_y_q;
	assign cx3 = prod_s1[4] + prod_s1[5] + shift_x_q;
	assign cy3 = prod_s1[6] + prod_s1[7] + shift_y_q;

	always_ff @(posedge clk) begin
		if (en2) begin
			cx_s2[0] <= cx0;
			cy_s2[0] <= cy0;
			cx_s2[1] <= is_rect ? cx1 : cx0;
			cy_s2[1] <= is_rect ? cy1 : cy0;
			cx_s2[2] <= is_rect ? cx2 : cx0;
			cy_s2[2] <= is_rect ? cy2 : cy0;
			cx_s2[3] <= is_rect ? cx3 : cx0;
			cy_s2[3] <= is_rect ? cy3 : cy0;
		end
	end

	// stage 3: min/max over corner pairs
	logic signed [W-1:0] xlo_a_s3, xhi_a_s3, xlo_b_s3, xhi_b_s3;
	logic signed [W-1:0] ylo_a_s3, yhi_a_s3, ylo_b_s3, yhi_b_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			xlo_a_s3 <= (cx_s2[1] < cx_s2[0]) ? cx_s2[1] : cx_s2[0];
			xhi_a_s3 <= (cx_s2[0] < cx_s2[1]) ? cx_s2[1] : cx_s2[0];
			xlo_b_s3 <= (cx_s2[3] < cx_s2[2]) ? cx_s2[3] : cx_s2[2];
			xhi_b_s3 <= (cx_s2[2] < cx_s2[3]) ? cx_s2[3] : cx_s2[2];
			ylo_a_s3 <= (cy_s2[1] < cy_s2[0]) ? cy_s2[1] : cy_s2[0];
			yhi_a_s3 <= (cy_s2[0] < cy_s2[1]) ? cy_s2[1] : cy_s2[0];
			ylo_b_s3 <= (cy_s2[3] < cy_s2[2]) ? cy_s2[3] : cy_s2[2];
			yhi_b_s3 <= (cy_s2[2] < cy_s2[3]) ? cy_s2[3] : cy_s2[2];
		end
	end

	// stage 4: final bounds, the output register
	logic signed [W-1:0] min_x_s4, min_y_s4, max_x_s4, max_y_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			min_x_s4 <= (xlo_b_s3 < xlo_a_s3) ? xlo_b_s3 : xlo_a_s3;
			max_x_s4 <= (xhi_a_s3 < xhi_b_s3) ? xhi_b_s3 : xhi_a_s3;
			min_y_s4 <= (ylo_b_s3 < ylo_a_s3) ? ylo_b_s3 : ylo_a_s3;
			max_y_s4 <= (yhi_a_s3 < yhi_b_s3) ? yhi_b_s3 : yhi_a_s3;
		end
	end

	assign result.valid = v_s4;
	assign result.min_x = min_x_s4;
	assign result.min_y = min_y_s4;
	assign result.max_x = max_x_s4;
	assign result.max_y = max_y_s4;

endmodule
`default_nettype wire

FILE: design/aprt_checker.sv
// Port-level checker for the affine transform core, bound to the top level
`default_nettype none
`include "affine_point_rect_transform_core_assert.svh"
module aprt_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            item_ready,
	input wire logic                            result_valid,
	input wire logic                            result_ready,
	input wire logic signed [aprt_pkg::WORD_W-1:0] min_x,
	input wire logic signed [aprt_pkg::WORD_W-1:0] min_y,
	input wire logic signed [aprt_pkg::WORD_W-1:0] max_x,
	input wire logic signed [aprt_pkg::WORD_W-1:0] max_y
);

	// a box never comes out inverted
	`APRT_ASSERT_SAME(a_box_x_order, clk, arst_n, result_valid, min_x <= max_x, "min_x above max_x")
	`APRT_ASSERT_SAME(a_box_y_order, clk, arst_n, result_valid, min_y <= max_y, "min_y above max_y")

	// a free result side never backs up the input side
	`APRT_ASSERT_SAME(a_no_stall, clk, arst_n, result_ready, item_ready, "input stalled while output free")

	// a held result keeps its box
	`APRT_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(min_x) && $stable(max_x) && $stable(min_y) && $stable(max_y), "held result changed")

endmodule

bind affine_point_rect_transform_core aprt_checker u_aprt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.min_x        (result.min_x),
	.min_y        (result.min_y),
	.max_x        (result.max_x),
	.max_y        (result.max_y)
);
`default_nettype wire
